### rtl/ascii_setpoint_command_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-point command parser
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASCII_SETPOINT_COMMAND_PARSER_ASSERT_SVH
`define ASCII_SETPOINT_COMMAND_PARSER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define ASCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASCP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define ASCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/ascp_pkg.sv
// ----------------------------------------------------------------------------
// Set-point command parser package
// Shared types, character codes and arithmetic constants.
// ----------------------------------------------------------------------------
package ascp_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned VAL_W  = 7;
  localparam int unsigned OUT_W  = 11;
  localparam int unsigned TGT_W  = 3;

  // pwm top count default
  localparam int unsigned PWM_TOP_DEFAULT = 255;

  // command characters
  localparam logic [BYTE_W-1:0] CH_F    = 8'h46;
  localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_SEP  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_1    = 8'h31;
  localparam logic [BYTE_W-1:0] CH_5    = 8'h35;
  localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

  // target codes
  localparam logic [TGT_W-1:0] TGT_FIRST_TEMP = 3'd1;
  localparam logic [TGT_W-1:0] TGT_LAST_TEMP  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MIN_PWM    = 3'd4;

  // arithmetic: temps scale by 16, pwm is (v*top+50)/100
  localparam int unsigned TEMP_SHIFT   = 4;
  localparam int unsigned ROUND_BIAS   = 50;
  localparam int unsigned TENS_WEIGHT  = 10;
  // divide by 100 as multiply by ceil(2^24/100), exact for numerators below 199728
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam int unsigned RECIP_W      = 18;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd167773;

  // parser states
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_GOT_F    = 3'd1,
    ST_GOT_A    = 3'd2,
    ST_GOT_TGT  = 3'd3,
    ST_GOT_SEP  = 3'd4,
    ST_GOT_TENS = 3'd5
  } parse_state_t;

  // decoded command from parser to scaler
  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic             pct;
    logic [VAL_W-1:0] value;
  } ascp_cmd_t;

endpackage

### rtl/ascp_parser.sv
// ----------------------------------------------------------------------------
// Set-point command parser state machine
// Walks the F A <target> _ <digit> <digit> sequence one word at a time and
// registers a decoded command on the second digit.
// ----------------------------------------------------------------------------
`include "ascii_setpoint_command_parser_assert.svh"

module ascp_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic [ascp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         overrun,
  input  logic                         advance,
  output logic                         cmd_valid,
  output ascp_pkg::ascp_cmd_t          cmd
);

  ascp_pkg::parse_state_t              parse_state, parse_state_next;
  logic [ascp_pkg::TGT_W-1:0]          target_index, target_index_next;
  logic [ascp_pkg::VAL_W-1:0]          digit_accum, digit_accum_next;

  logic                                fire;
  logic                                is_digit;
  logic                                is_target;
  logic [ascp_pkg::BYTE_W-1:0]         byte_off;
  logic [3:0]                          digit;
  logic [ascp_pkg::VAL_W-1:0]          digit_tens;
  logic [ascp_pkg::VAL_W-1:0]          digit_sum;
  logic                                emit;
  ascp_pkg::ascp_cmd_t                 cmd_next;

  // character decode
  assign fire       = item_valid && advance;
  assign byte_off   = rx_byte - ascp_pkg::CH_0;
  assign digit      = byte_off[3:0];
  assign is_digit   = rx_byte inside {[ascp_pkg::CH_0:ascp_pkg::CH_9]};
  assign is_target  = rx_byte inside {[ascp_pkg::CH_1:ascp_pkg::CH_5]};
  assign digit_tens = ascp_pkg::VAL_W'({3'b000, digit} * 7'(ascp_pkg::TENS_WEIGHT));
  assign digit_sum  = digit_accum + ascp_pkg::VAL_W'(digit);

  // next state
  always_comb begin
    parse_state_next  = parse_state;
    target_index_next = target_index;
    digit_accum_next  = digit_accum;
    if (fire) begin
      if (overrun) begin
        parse_state_next = ascp_pkg::ST_IDLE;
      end else begin
        case (parse_state)
          ascp_pkg::ST_IDLE: begin
            parse_state_next = (rx_byte == ascp_pkg::CH_F) ? ascp_pkg::ST_GOT_F
                                                           : ascp_pkg::ST_IDLE;
          end
          ascp_pkg::ST_GOT_F: begin
            parse_state_next = (rx_byte == ascp_pkg::CH_A) ? ascp_pkg::ST_GOT_A
                                                           : ascp_pkg::ST_IDLE;
          end
          ascp_pkg::ST_GOT_A: begin
            if (is_target) begin
              parse_state_next  = ascp_pkg::ST_GOT_TGT;
              target_index_next = byte_off[ascp_pkg::TGT_W-1:0];
              digit_accum_next  = '0;
            end else begin
              parse_state_next = ascp_pkg::ST_IDLE;
            end
          end
          ascp_pkg::ST_GOT_TGT: begin
            parse_state_next = (rx_byte == ascp_pkg::CH_SEP) ? ascp_pkg::ST_GOT_SEP
                                                             : ascp_pkg::ST_IDLE;
          end
          ascp_pkg::ST_GOT_SEP: begin
            if (is_digit) begin
              parse_state_next = ascp_pkg::ST_GOT_TENS;
              digit_accum_next = digit_tens;
            end else begin
              parse_state_next = ascp_pkg::ST_IDLE;
            end
          end
          ascp_pkg::ST_GOT_TENS: begin
            parse_state_next = ascp_pkg::ST_IDLE;
            if (is_digit) begin
              digit_accum_next = digit_sum;
            end
          end
          default: begin
            parse_state_next = ascp_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  // command decode on the second digit
  always_comb begin
    emit = fire && !overrun && (parse_state == ascp_pkg::ST_GOT_TENS) && is_digit;
    cmd_next.value = digit_sum;
    if ((target_index >= ascp_pkg::TGT_FIRST_TEMP) &&
        (target_index <= ascp_pkg::TGT_LAST_TEMP)) begin
      cmd_next.sel = ascp_pkg::SEL_W'(target_index - ascp_pkg::TGT_FIRST_TEMP);
      cmd_next.pct = 1'b0;
    end else begin
      cmd_next.sel = ascp_pkg::SEL_MIN_PWM;
      cmd_next.pct = 1'b1;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= ascp_pkg::ST_IDLE;
      target_index <= '0;
      digit_accum  <= '0;
    end else begin
      parse_state  <= parse_state_next;
      target_index <= target_index_next;
      digit_accum  <= digit_accum_next;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd <= cmd_next;
    end
  end

  // checks
  `ASCP_ASSERT_NEXT(a_emit_only_from_tens, clk, rst,
    fire && (parse_state != ascp_pkg::ST_GOT_TENS), !cmd_valid,
    "command emitted outside the second digit")
  `ASCP_ASSERT_NEXT(a_overrun_to_idle, clk, rst,
    fire && overrun, (parse_state == ascp_pkg::ST_IDLE) && !cmd_valid,
    "overrun did not return parser to idle")
  `ASCP_ASSERT_NOW(a_cmd_kind, clk, rst,
    cmd_valid, cmd.pct == (cmd.sel == ascp_pkg::SEL_MIN_PWM),
    "command scaling kind does not match target")

endmodule

### rtl/ascp_scale.sv
// ----------------------------------------------------------------------------
// Set-point value scaler
// Two-stage datapath: forms the numerator, then scales to the register value.
// Temperatures are value times 16, min pwm is (value*top+50)/100.
// ----------------------------------------------------------------------------
`include "ascii_setpoint_command_parser_assert.svh"

module ascp_scale #(
  parameter int unsigned PWM_TOP = ascp_pkg::PWM_TOP_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  ascp_pkg::ascp_cmd_t          cmd,
  output logic                         cmd_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ascp_pkg::SEL_W-1:0]   reg_select,
  output logic [ascp_pkg::OUT_W-1:0]   write_value
);

  localparam int unsigned NUM_MAX = ((1 << ascp_pkg::VAL_W) - 1) * PWM_TOP
                                    + ascp_pkg::ROUND_BIAS;
  localparam int unsigned PCT_W   = $clog2(NUM_MAX + 1);
  localparam int unsigned NUM_W   = (PCT_W > ascp_pkg::OUT_W) ? PCT_W : ascp_pkg::OUT_W;
  localparam int unsigned PROD_W  = ascp_pkg::RECIP_SHIFT + ascp_pkg::OUT_W;

  logic                          out_ready;
  logic                          num_ready;
  logic                          num_valid;
  logic [ascp_pkg::SEL_W-1:0]    num_sel;
  logic                          num_pct;
  logic [NUM_W-1:0]              num;
  logic [NUM_W-1:0]              num_next;
  logic [PROD_W-1:0]             prod;
  logic [ascp_pkg::OUT_W-1:0]    value_next;

  // ready chain
  assign out_ready = !out_valid || !out_stall;
  assign num_ready = !num_valid || out_ready;
  assign cmd_ready = num_ready;

  // numerator
  always_comb begin
    if (cmd.pct) begin
      num_next = NUM_W'(cmd.value) * NUM_W'(PWM_TOP) + NUM_W'(ascp_pkg::ROUND_BIAS);
    end else begin
      num_next = NUM_W'(cmd.value) << ascp_pkg::TEMP_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else if (num_ready) begin
      num_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (num_ready) begin
      num_sel <= cmd.sel;
      num_pct <= cmd.pct;
      num     <= num_next;
    end
  end

  // divide by 100 through the reciprocal
  assign prod       = PROD_W'(num) * PROD_W'(ascp_pkg::RECIP_MULT);
  assign value_next = num_pct ? prod[ascp_pkg::RECIP_SHIFT +: ascp_pkg::OUT_W]
                              : num[ascp_pkg::OUT_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      reg_select  <= num_sel;
      write_value <= value_next;
    end
  end

  // checks
  `ASCP_ASSERT_NOW(a_temp_num_aligned, clk, rst,
    num_valid && !num_pct, num[ascp_pkg::TEMP_SHIFT-1:0] == '0,
    "temperature numerator not a multiple of 16")
  `ASCP_ASSERT_NOW(a_temp_out_aligned, clk, rst,
    out_valid && (reg_select != ascp_pkg::SEL_MIN_PWM),
    write_value[ascp_pkg::TEMP_SHIFT-1:0] == '0,
    "temperature value not a multiple of 16")
  `ASCP_ASSERT_NOW(a_pwm_in_range, clk, rst,
    out_valid && (reg_select == ascp_pkg::SEL_MIN_PWM),
    write_value <= ascp_pkg::OUT_W'(PWM_TOP),
    "min pwm value above top count")

endmodule

### rtl/ascii_setpoint_command_parser.sv
// ----------------------------------------------------------------------------
// ASCII set-point command parser
// Takes one received word per cycle unless in_stall is high, and recognizes
// F A <1..5> _ <d> <d>. An unexpected word or an overrun returns the parser
// to idle. The second digit yields one register write: targets 1..4 get the
// value times 16, target 5 gets (value*PWM_TOP+50)/100. A new word is taken
// every cycle while in_stall is low; a command's last word passes from the
// input register through the parser command register, the numerator register
// and the result register. Bubbles in the pipeline are squeezed out, so input
// keeps flowing while a result waits on the output, until the registers fill.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser #(
  parameter int unsigned PWM_TOP = ascp_pkg::PWM_TOP_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ascp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         overrun,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ascp_pkg::SEL_W-1:0]   reg_select,
  output logic [ascp_pkg::OUT_W-1:0]   write_value
);

  logic                          word_valid;
  logic [ascp_pkg::BYTE_W-1:0]   word_byte;
  logic                          word_overrun;
  logic                          word_ready;
  logic                          parse_ready;
  logic                          cmd_valid;
  logic                          cmd_ready;
  ascp_pkg::ascp_cmd_t           cmd;

  // ready chain
  assign parse_ready = !cmd_valid || cmd_ready;
  assign word_ready  = !word_valid || parse_ready;
  assign in_stall    = !word_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (word_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready) begin
      word_byte    <= rx_byte;
      word_overrun <= overrun;
    end
  end

  // sequence parser
  ascp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (word_valid),
    .rx_byte    (word_byte),
    .overrun    (word_overrun),
    .advance    (parse_ready),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  // value scaling and result register
  ascp_scale #(
    .PWM_TOP (PWM_TOP)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_select  (reg_select),
    .write_value (write_value)
  );

endmodule

### tb/setpoint_write_checker.sv
// ----------------------------------------------------------------------------
// Set-point write checker
// Watches both channels of the command parser. Every accepted word goes
// through a local copy of the parser, which queues the register write it
// should cause. Each accepted write is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module setpoint_write_checker #(
  parameter int unsigned PWM_TOP = ascp_pkg::PWM_TOP_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [ascp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         overrun,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ascp_pkg::SEL_W-1:0]   reg_select,
  input  logic [ascp_pkg::OUT_W-1:0]   write_value,
  output int                           error_count,
  output int                           pending,
  output int                           words_seen,
  output int                           writes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PCT_SCALE = 100;

  typedef struct packed {
    logic [ascp_pkg::SEL_W-1:0] sel;
    logic [ascp_pkg::OUT_W-1:0] value;
  } fan_write_t;

  // local parser state
  ascp_pkg::parse_state_t     state_q;
  logic [ascp_pkg::TGT_W-1:0] target_q;
  logic [ascp_pkg::VAL_W-1:0] accum_q;

  fan_write_t expected_writes[$];

  // advance the local parser by one word, queue any write it produces
  task automatic parse_word(input logic [ascp_pkg::BYTE_W-1:0] b, input logic ovr);
    logic                       is_digit;
    int unsigned                digit;
    logic [ascp_pkg::VAL_W-1:0] total;
    fan_write_t                 w;
    is_digit = (b >= ascp_pkg::CH_0) && (b <= ascp_pkg::CH_9);
    digit    = 32'(b) - 32'(ascp_pkg::CH_0);
    if (ovr) begin
      state_q = ascp_pkg::ST_IDLE;
    end else begin
      case (state_q)
        ascp_pkg::ST_IDLE: begin
          state_q = (b == ascp_pkg::CH_F) ? ascp_pkg::ST_GOT_F : ascp_pkg::ST_IDLE;
        end
        ascp_pkg::ST_GOT_F: begin
          state_q = (b == ascp_pkg::CH_A) ? ascp_pkg::ST_GOT_A : ascp_pkg::ST_IDLE;
        end
        ascp_pkg::ST_GOT_A: begin
          if (b >= ascp_pkg::CH_1 && b <= ascp_pkg::CH_5) begin
            state_q  = ascp_pkg::ST_GOT_TGT;
            target_q = ascp_pkg::TGT_W'(digit);
            accum_q  = '0;
          end else begin
            state_q = ascp_pkg::ST_IDLE;
          end
        end
        ascp_pkg::ST_GOT_TGT: begin
          state_q = (b == ascp_pkg::CH_SEP) ? ascp_pkg::ST_GOT_SEP : ascp_pkg::ST_IDLE;
        end
        ascp_pkg::ST_GOT_SEP: begin
          if (is_digit) begin
            accum_q = ascp_pkg::VAL_W'(digit * ascp_pkg::TENS_WEIGHT);
            state_q = ascp_pkg::ST_GOT_TENS;
          end else begin
            state_q = ascp_pkg::ST_IDLE;
          end
        end
        ascp_pkg::ST_GOT_TENS: begin
          state_q = ascp_pkg::ST_IDLE;
          if (is_digit) begin
            total   = ascp_pkg::VAL_W'(32'(accum_q) + digit);
            accum_q = total;
            // temperature targets scale by 16, the pwm target is a rounded percentage
            if (target_q >= ascp_pkg::TGT_FIRST_TEMP &&
                target_q <= ascp_pkg::TGT_LAST_TEMP) begin
              w.sel   = ascp_pkg::SEL_W'(target_q - ascp_pkg::TGT_FIRST_TEMP);
              w.value = ascp_pkg::OUT_W'(32'(total) << ascp_pkg::TEMP_SHIFT);
            end else begin
              w.sel   = ascp_pkg::SEL_MIN_PWM;
              w.value = ascp_pkg::OUT_W'((32'(total) * PWM_TOP + ascp_pkg::ROUND_BIAS)
                                         / PCT_SCALE);
            end
            expected_writes.push_back(w);
          end
        end
        default: begin
          state_q = ascp_pkg::ST_IDLE;
        end
      endcase
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    fan_write_t want;
    if (rst) begin
      state_q  = ascp_pkg::ST_IDLE;
      target_q = '0;
      accum_q  = '0;
      expected_writes.delete();
      error_count    <= 0;
      pending        <= 0;
      words_seen     <= 0;
      writes_checked <= 0;
    end else begin
      // compare an accepted write with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write: reg_select %0d, write_value %0d", reg_select,
                 write_value);
          error_count <= error_count + 1;
        end else begin
          want = expected_writes.pop_front();
          if (reg_select !== want.sel || write_value !== want.value) begin
            if (reg_select !== want.sel) begin
              $error("reg_select: expected %0d, actual %0d", want.sel, reg_select);
            end
            if (write_value !== want.value) begin
              $error("write_value: expected %0d, actual %0d", want.value, write_value);
            end
            error_count <= error_count + 1;
          end
          writes_checked <= writes_checked + 1;
        end
      end
      // accepted word
      if (in_valid && !in_stall) begin
        parse_word(rx_byte, overrun);
        words_seen <= words_seen + 1;
      end
      pending <= expected_writes.size();
    end
  end

endmodule

### tb/ascii_setpoint_command_parser_test.sv
// ----------------------------------------------------------------------------
// Set-point command parser testbench
// Sends a few directed commands, then random command streams with corrupted,
// cut-short and overrun words mixed in, with random gaps on the input and
// random stalls on the output. The checker predicts and compares the writes.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PWM_TOP      = ascp_pkg::PWM_TOP_DEFAULT;
  localparam int          CMD_WORDS    = 1950;
  localparam int          WATCHDOG_MAX = 1000;
  localparam int          DRAIN_CYCLES = 20;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic [ascp_pkg::BYTE_W-1:0] rx_byte     = '0;
  logic                        overrun     = 1'b0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic [ascp_pkg::SEL_W-1:0]  reg_select;
  logic [ascp_pkg::OUT_W-1:0]  write_value;

  int error_count;
  int pending;
  int words_seen;
  int writes_checked;

  int burst_left      = 0;
  int cmd_words_sent  = 0;
  int commands_sent   = 0;
  int commands_broken = 0;
  int idle_cycles     = 0;

  ascii_setpoint_command_parser #(
    .PWM_TOP (PWM_TOP)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .overrun     (overrun),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_select  (reg_select),
    .write_value (write_value)
  );

  setpoint_write_checker #(
    .PWM_TOP (PWM_TOP)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .overrun        (overrun),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reg_select     (reg_select),
    .write_value    (write_value),
    .error_count    (error_count),
    .pending        (pending),
    .words_seen     (words_seen),
    .writes_checked (writes_checked)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(input logic [ascp_pkg::BYTE_W-1:0] b, input logic ovr);
    int gap;
    gap = (burst_left > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    overrun  <= ovr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  // one command with random content, sometimes corrupted or cut short
  task automatic send_command();
    logic [ascp_pkg::BYTE_W-1:0] cmd [6];
    logic                        ovr [6];
    int                          bad_pos;
    int                          len;
    cmd[0] = ascp_pkg::CH_F;
    cmd[1] = ascp_pkg::CH_A;
    cmd[2] = ascp_pkg::CH_1 + ascp_pkg::BYTE_W'($urandom_range(0, 4));
    cmd[3] = ascp_pkg::CH_SEP;
    cmd[4] = ascp_pkg::CH_0 + ascp_pkg::BYTE_W'($urandom_range(0, 9));
    cmd[5] = ascp_pkg::CH_0 + ascp_pkg::BYTE_W'($urandom_range(0, 9));
    for (int i = 0; i < 6; i++) ovr[i] = 1'b0;
    len = 6;
    if ($urandom_range(0, 99) < 25) begin
      bad_pos = $urandom_range(0, 5);
      commands_broken++;
      case ($urandom_range(0, 3))
        0: cmd[bad_pos] = ascp_pkg::BYTE_W'($urandom_range(0, 255));
        1: ovr[bad_pos] = 1'b1;
        2: cmd[bad_pos] = cmd[bad_pos] ^ 8'h20;
        default: len = bad_pos;
      endcase
    end
    for (int i = 0; i < len; i++) begin
      send_word(cmd[i], ovr[i]);
    end
    cmd_words_sent += len;
    commands_sent++;
  endtask

  // output stalls: random holds, short free runs, now and then a long free run
  initial begin : stall_driver
    int hold;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $error("watchdog: no word accepted for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: zero on a temp target, max on pwm, max on a temp target
    send_string("FA1_00");
    send_string("FA5_99");
    send_string("FA4_99");
    // overrun on the last digit drops the command
    send_string("FA4_9");
    send_word(ascp_pkg::CH_9, 1'b1);
    // overrun on the leading F, rest of the command ignored
    send_word(ascp_pkg::CH_F, 1'b1);
    send_string("A2_5");
    // target just out of range
    send_string("FA6");

    // random commands with noise between them
    while (cmd_words_sent < CMD_WORDS) begin
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left = $urandom_range(10, 30);
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(ascp_pkg::BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end
      end
      send_command();
    end
    in_valid <= 1'b0;

    // drain outstanding writes, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d random commands (%0d corrupted or cut short)",
             words_seen, commands_sent, commands_broken);
    $display("checked %0d register writes, %0d mismatches", writes_checked, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### ascii_setpoint_command_parser.f
+incdir+rtl
rtl/ascp_pkg.sv
rtl/ascp_parser.sv
rtl/ascp_scale.sv
rtl/ascii_setpoint_command_parser.sv
tb/setpoint_write_checker.sv
tb/ascii_setpoint_command_parser_test.sv
